/* src/dfo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfo_pkg
// Shared types, sizes and helpers for the depth-first order block.
// ----------------------------------------------------------------------------
package dfo_pkg;

  localparam int NUM_VERT = 64;               // vertices held by the matrix
  localparam int VID_W    = 6;                // vertex number width
  localparam int CNT_W    = 7;                // vertex count / stack depth width

  typedef logic [VID_W-1:0]    vid_t;
  typedef logic [NUM_VERT-1:0] row_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // adjacency memory request: set bit (addr, col), or drop all rows
  typedef struct packed {
    logic wr;
    logic clr;
    vid_t addr;
    vid_t col;
  } adj_req_t;

  function automatic row_t onehot(input vid_t v);
    row_t r;
    r = '0;
    r[v] = 1'b1;
    return r;
  endfunction

  // lowest set bit; all-zero input gives zero (never used that way)
  function automatic vid_t lowest(input row_t x);
    vid_t r;
    r = '0;
    for (int i = NUM_VERT - 1; i >= 0; i--) begin
      if (x[i]) r = vid_t'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/graph_depth_first_order.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_depth_first_order
// Depth-first visit order over an undirected graph kept as a bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low.
//   func = 0 adds the undirected edge (first_vertex, second_vertex); either
//   endpoint at or above vertex_count drops the edge. A kept edge makes one
//   matrix row write each way through the single write port, the second in
//   S_EDGE; a dropped one leaves busy low.
//   func = 1 runs the traversal: each vertex comes out on vertex with
//   result_strobe high for one cycle, last_of_run marks the final one. The
//   receiver cannot stall; results are not held.
//   A discovered vertex takes row read, candidate mask and pick; a backtrack
//   takes stack RAM read, candidate mask and step; a component restart and
//   the finish take S_SEEK and S_START. These steps come from the registered
//   reads of the matrix and stack RAMs and the registered candidate vector.
//   The last result strobes in the cycle busy drops.
//   After a run the matrix and visited marks are empty (row valid bits clear
//   all at once, no sweep).
//   config_write/config_data set vertex_count; write only while idle.
//   Reset (rst, synchronous): empty matrix, vertex_count = 64, idle.
// ----------------------------------------------------------------------------
module graph_depth_first_order (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 func,
  input  wire dfo_pkg::vid_t        first_vertex,
  input  wire dfo_pkg::vid_t        second_vertex,
  input  wire logic                 config_write,
  input  wire dfo_pkg::cnt_t        config_data,
  output logic                      result_strobe,
  output dfo_pkg::vid_t             vertex,
  output logic                      last_of_run
);
  import dfo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request
    S_EDGE,   // second half of an edge write
    S_SEEK,   // latch unvisited set
    S_START,  // start next component or finish
    S_READ,   // read row of stack top
    S_CAND,   // latch unvisited neighbors
    S_STEP,   // descend or backtrack
    S_POP     // new top arrives from stack RAM
  } state_t;

  state_t   state;
  cnt_t     vertex_count;
  vid_t     edge_a;
  vid_t     edge_b;
  row_t     visited;
  row_t     cand;          // candidate set (neighbors, or unvisited on seek)
  vid_t     top;
  cnt_t     depth;
  logic     pend_valid;    // one result held back to learn if it is last
  vid_t     pend_vertex;

  row_t     mask;
  row_t     adj_row;
  adj_req_t adj_req;
  vid_t     pick;
  logic     accept;
  logic     edge_ok;
  cnt_t     depth_m2;

  logic     stk_we;
  vid_t     stk_waddr;
  vid_t     stk_wdata;
  vid_t     stk_rdata;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign edge_ok  = ({1'b0, first_vertex} < vertex_count) &&
                    ({1'b0, second_vertex} < vertex_count);
  assign pick     = lowest(cand);
  assign depth_m2 = depth - cnt_t'(2);

  // vertices in use; a count above the matrix size means all of it
  always_comb begin
    if (vertex_count >= cnt_t'(NUM_VERT)) mask = '1;
    else                                  mask = (row_t'(1) << vertex_count) - row_t'(1);
  end

  // matrix requests
  always_comb begin
    adj_req      = '0;
    adj_req.addr = top;
    case (state)
      S_IDLE: begin
        if (accept && !func && edge_ok) begin
          adj_req.wr   = 1'b1;
          adj_req.addr = first_vertex;
          adj_req.col  = second_vertex;
        end
      end
      S_EDGE: begin
        adj_req.wr   = 1'b1;
        adj_req.addr = edge_b;
        adj_req.col  = edge_a;
      end
      S_START: adj_req.clr = (cand == '0);
      S_POP:   adj_req.addr = stk_rdata;
      default: ;
    endcase
  end

  // stack pushes: new component root at 0, descent at current depth
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = depth[VID_W-1:0];
    stk_wdata = pick;
    case (state)
      S_START: begin
        stk_we    = (cand != '0);
        stk_waddr = '0;
      end
      S_STEP:  stk_we = (cand != '0) && (depth < cnt_t'(NUM_VERT));
      default: ;
    endcase
  end

  dfo_adj_mem u_adj (
    .clk (clk),
    .rst (rst),
    .req (adj_req),
    .row (adj_row)
  );

  dfo_ram #(
    .WIDTH (VID_W),
    .DEPTH (NUM_VERT)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (depth_m2[VID_W-1:0]),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= cnt_t'(NUM_VERT);
      visited       <= '0;
      depth         <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
      last_of_run   <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (config_write) vertex_count <= config_data;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (func) begin
              visited <= '0;
              depth   <= '0;
              state   <= S_SEEK;
            end else if (edge_ok) begin
              edge_a <= first_vertex;
              edge_b <= second_vertex;
              state  <= S_EDGE;
            end
          end
        end
        S_EDGE: state <= S_IDLE;
        S_SEEK: begin
          cand  <= ~visited & mask;
          state <= S_START;
        end
        S_START: begin
          if (cand == '0) begin
            // done: flush held result as the last one
            if (pend_valid) begin
              result_strobe <= 1'b1;
              vertex        <= pend_vertex;
              last_of_run   <= 1'b1;
            end
            pend_valid <= 1'b0;
            visited    <= '0;
            depth      <= '0;
            state      <= S_IDLE;
          end else begin
            if (pend_valid) begin
              result_strobe <= 1'b1;
              vertex        <= pend_vertex;
              last_of_run   <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_vertex <= pick;
            visited     <= visited | onehot(pick);
            top         <= pick;
            depth       <= cnt_t'(1);
            state       <= S_READ;
          end
        end
        S_READ: state <= S_CAND;
        S_CAND: begin
          // self-loops are never followed
          cand  <= adj_row & ~visited & mask & ~onehot(top);
          state <= S_STEP;
        end
        S_STEP: begin
          if (cand != '0) begin
            if (pend_valid) begin
              result_strobe <= 1'b1;
              vertex        <= pend_vertex;
              last_of_run   <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_vertex <= pick;
            visited     <= visited | onehot(pick);
            if (depth < cnt_t'(NUM_VERT)) begin
              top   <= pick;
              depth <= depth + cnt_t'(1);
            end
            state <= S_READ;
          end else begin
            depth <= depth - cnt_t'(1);
            state <= (depth > cnt_t'(1)) ? S_POP : S_SEEK;
          end
        end
        S_POP: begin
          top   <= stk_rdata;
          state <= S_CAND;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/dfo_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfo_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dfo_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/dfo_adj_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfo_adj_mem
// Adjacency bit matrix: bit-set writes, registered row read, row valid bits
// so the whole matrix clears all at once.
// ----------------------------------------------------------------------------
module dfo_adj_mem (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dfo_pkg::adj_req_t req,
  output dfo_pkg::row_t          row
);
  import dfo_pkg::*;

  row_t mem [NUM_VERT];
  row_t row_valid;
  row_t rd_data;
  logic rd_valid;

  // first write to a stale row overwrites it whole
  always_ff @(posedge clk) begin
    if (req.wr) begin
      if (row_valid[req.addr]) mem[req.addr][req.col] <= 1'b1;
      else                     mem[req.addr] <= onehot(req.col);
    end
    rd_data <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= row_valid[req.addr];
      if (req.clr)     row_valid <= '0;
      else if (req.wr) row_valid[req.addr] <= 1'b1;
    end
  end

  assign row = rd_valid ? rd_data : '0;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for graph_depth_first_order: edge loads and depth-first
// traversals are predicted in the bench and every visit result is compared
// in order against the predicted visit sequence.
// ----------------------------------------------------------------------------
module tb_top;
  import dfo_pkg::*;

  localparam logic FUNC_ADD_EDGE = 1'b0;
  localparam logic FUNC_RUN      = 1'b1;
  localparam int   STALL_LIMIT   = 4000;   // cycles with no request or result
  localparam int   SETTLE_CYCLES = 4;      // room for an add-edge to finish its writes after accept

  // one predicted visit result
  typedef struct packed {
    vid_t vtx;
    logic last;
  } visit_t;

  logic clk           = 1'b0;
  logic rst           = 1'b1;
  logic start         = 1'b0;
  logic func          = 1'b0;
  vid_t first_vertex  = '0;
  vid_t second_vertex = '0;
  logic config_write  = 1'b0;
  cnt_t config_data   = '0;
  logic busy;
  logic result_strobe;
  vid_t vertex;
  logic last_of_run;

  // bench copy of the graph state
  logic [NUM_VERT-1:0] adj_rows [NUM_VERT];
  cnt_t                vcount;
  visit_t              expected_visits [$];

  int  mismatch_count = 0;
  int  requests_sent  = 0;
  int  edge_loads     = 0;
  int  traversals     = 0;
  int  visits_checked = 0;
  int  idle_cycles    = 0;
  bit  gaps_on        = 1'b1;

  graph_depth_first_order uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .config_write  (config_write),
    .config_data   (config_data),
    .result_strobe (result_strobe),
    .vertex        (vertex),
    .last_of_run   (last_of_run)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Visit-order predictor
  // --------------------------------------------------------------------------

  // counts above the matrix size behave as a full matrix
  function automatic int active_vertices();
    return (int'(vcount) > NUM_VERT) ? NUM_VERT : int'(vcount);
  endfunction

  // index of the lowest set bit, -1 if none
  function automatic int first_set(input logic [NUM_VERT-1:0] x);
    int  idx;
    bit  hit;
    idx = -1;
    hit = 1'b0;
    for (int i = 0; i < NUM_VERT; i++) begin
      if (!hit && x[i]) begin
        idx = i;
        hit = 1'b1;
      end
    end
    return idx;
  endfunction

  task automatic predict_request(input logic f, input vid_t a, input vid_t b);
    int                  n_act;
    logic [NUM_VERT-1:0] in_use;
    logic [NUM_VERT-1:0] seen;
    logic [NUM_VERT-1:0] cand;
    int                  path [NUM_VERT];
    int                  depth;
    int                  top;
    int                  nxt;
    int                  order [$];
    visit_t              item;
    n_act  = active_vertices();
    in_use = (n_act >= NUM_VERT) ? '1 : ((64'd1 << n_act) - 64'd1);
    if (f == FUNC_ADD_EDGE) begin
      // either endpoint outside the active range drops the edge
      if (int'(a) < n_act && int'(b) < n_act) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      edge_loads++;
    end else begin
      seen = '0;
      // one outer pass per component, rooted at the lowest unseen vertex
      while ((~seen & in_use) != '0) begin
        top = first_set(~seen & in_use);
        seen[top] = 1'b1;
        order.push_back(top);
        path[0] = top;
        depth   = 1;
        while (depth > 0) begin
          top  = path[depth-1];
          // self-loops are masked off here: stored but never taken
          cand = adj_rows[top] & ~seen & in_use;
          cand[top] = 1'b0;
          if (cand != '0) begin
            nxt = first_set(cand);
            seen[nxt] = 1'b1;
            order.push_back(nxt);
            if (depth < NUM_VERT) begin
              path[depth] = nxt;
              depth++;
            end
          end else begin
            depth--;
          end
        end
      end
      foreach (order[i]) begin
        item.vtx  = vid_t'(order[i]);
        item.last = (i == order.size() - 1);
        expected_visits.push_back(item);
      end
      // a run always leaves an empty matrix, even with zero vertices
      for (int r = 0; r < NUM_VERT; r++) adj_rows[r] = '0;
      traversals++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking and watchdog
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_visits
    visit_t head;
    if (!rst && result_strobe) begin
      if (expected_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected result vertex=%0d last=%0b",
                                  vertex, last_of_run));
      end else begin
        head = expected_visits.pop_front();
        visits_checked++;
        if (vertex !== head.vtx)
          report_mismatch($sformatf("vertex got %0d, want %0d", vertex, head.vtx));
        if (last_of_run !== head.last)
          report_mismatch($sformatf("last_of_run got %0b, want %0b at vertex %0d",
                                    last_of_run, head.last, head.vtx));
      end
    end
  end

  // counts cycles in which neither a request nor a result moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no progress for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver helpers (all entered and left right after a rising edge)
  // --------------------------------------------------------------------------

  // start stays high on return so a following request can go back to back
  task automatic send_request(input logic f, input vid_t a, input vid_t b);
    start         <= 1'b1;
    func          <= f;
    first_vertex  <= a;
    second_vertex <= b;
    do @(posedge clk); while (busy);
    predict_request(f, a, b);
    requests_sent++;
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic add_edge(input vid_t a, input vid_t b);
    send_request(FUNC_ADD_EDGE, a, b);
    maybe_gap();
  endtask

  // vertex fields are don't-care on a run, so they carry noise
  task automatic run_traversal();
    send_request(FUNC_RUN, vid_t'($urandom), vid_t'($urandom));
    maybe_gap();
  endtask

  // sender holds off until every predicted visit has come out
  task automatic drain_results();
    start <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk);
  endtask

  task automatic set_vertex_count(input cnt_t value);
    drain_results();
    while (busy) @(posedge clk);
    // a trailing add-edge has no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
    config_write <= 1'b1;
    config_data  <= value;
    @(posedge clk);
    config_write <= 1'b0;
    vcount = value;
  endtask

  // mostly in range, some self-loops, some anywhere in the 6-bit field
  task automatic random_edge(input int n_act);
    vid_t a;
    vid_t b;
    int   pick;
    pick = $urandom_range(0, 9);
    if (n_act > 0 && pick < 8) begin
      a = vid_t'($urandom_range(0, n_act - 1));
      b = vid_t'($urandom_range(0, n_act - 1));
    end else begin
      a = vid_t'($urandom);
      b = vid_t'($urandom);
    end
    if (pick == 9) b = a;
    add_edge(a, b);
  endtask

  // small counts dominate; full, zero and over-range settings show up too
  function automatic cnt_t random_count();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return cnt_t'($urandom_range(2, 12));
    if (pick < 15) return cnt_t'($urandom_range(13, 40));
    if (pick < 17) return cnt_t'(NUM_VERT);
    if (pick < 18) return cnt_t'($urandom_range(65, 127));
    if (pick < 19) return cnt_t'(1);
    return cnt_t'(0);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // count left at its reset value of 64
  task automatic test_reset_defaults();
    run_traversal();                 // no edges: every vertex its own component
    add_edge(6'd0, 6'd63);
    add_edge(6'd63, 6'd0);           // duplicate, no effect
    add_edge(6'd5, 6'd5);            // self-loop, never followed
    add_edge(6'd63, 6'd62);
    run_traversal();
  endtask

  task automatic test_small_counts();
    set_vertex_count(cnt_t'(1));
    add_edge(6'd0, 6'd0);
    run_traversal();                 // single vertex, flagged last
    set_vertex_count(cnt_t'(8));
    add_edge(6'd7, 6'd0);
    add_edge(6'd8, 6'd1);            // endpoint at the count, dropped
    add_edge(6'd0, 6'd63);           // far out of range, dropped
    add_edge(6'd3, 6'd3);
    add_edge(6'd2, 6'd7);
    run_traversal();
  endtask

  // a zero-count run gives nothing but still wipes the matrix
  task automatic test_count_zero();
    set_vertex_count(cnt_t'(NUM_VERT));
    add_edge(6'd1, 6'd5);
    set_vertex_count(cnt_t'(0));
    add_edge(6'd0, 6'd0);
    run_traversal();
    set_vertex_count(cnt_t'(NUM_VERT));
    run_traversal();                 // old edge must be gone
  endtask

  task automatic test_count_over_limit();
    set_vertex_count(cnt_t'(127));
    add_edge(6'd63, 6'd0);
    add_edge(6'd1, 6'd62);
    run_traversal();
    set_vertex_count(cnt_t'(65));
    add_edge(6'd40, 6'd2);
    run_traversal();
  endtask

  // one shuffled path through all 64 vertices; the stack reaches full depth only when vertex 0 is an end of it
  task automatic test_deep_chain();
    int perm [NUM_VERT];
    int j;
    int tmp;
    set_vertex_count(cnt_t'(NUM_VERT));
    for (int i = 0; i < NUM_VERT; i++) perm[i] = i;
    for (int i = NUM_VERT - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < NUM_VERT - 1; i++) begin
      if ($urandom_range(0, 1)) add_edge(vid_t'(perm[i]), vid_t'(perm[i+1]));
      else                      add_edge(vid_t'(perm[i+1]), vid_t'(perm[i]));
    end
    run_traversal();
  endtask

  task automatic test_drain_pause();
    set_vertex_count(cnt_t'(16));
    repeat (5) random_edge(16);
    run_traversal();
    drain_results();
    repeat (3) random_edge(16);
    run_traversal();
  endtask

  task automatic test_random_graphs(input int n_requests);
    int   stop_at;
    int   n_act;
    int   shape;
    stop_at = requests_sent + n_requests;
    while (requests_sent < stop_at) begin
      set_vertex_count(random_count());
      n_act = active_vertices();
      repeat ($urandom_range(1, 3)) begin
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          // noise only: endpoints anywhere
          repeat ($urandom_range(1, 6))
            add_edge(vid_t'($urandom), vid_t'($urandom));
        end else if (shape != 1) begin
          repeat ($urandom_range(1, 14)) random_edge(n_act);
        end
        // shape 1: run on an empty matrix
        if ($urandom_range(0, 9) == 0) drain_results();
        run_traversal();
      end
    end
  endtask

  // closing stretch with start held high once the count is set
  task automatic test_back_to_back();
    int n_act;
    gaps_on = 1'b0;
    set_vertex_count(cnt_t'($urandom_range(4, 16)));
    n_act = active_vertices();
    repeat (2) begin
      repeat (8) random_edge(n_act);
      run_traversal();
    end
    run_traversal();
    random_edge(n_act);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int r = 0; r < NUM_VERT; r++) adj_rows[r] = '0;
    vcount = cnt_t'(NUM_VERT);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_small_counts();
    test_count_zero();
    test_count_over_limit();
    test_deep_chain();
    test_drain_pause();
    test_random_graphs(140);
    test_back_to_back();

    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests: %0d edge loads, %0d traversals, %0d visits checked",
             requests_sent, edge_loads, traversals, visits_checked);
    $display("Vertex counts from zero to over-range, full-depth chain, noise edges");
    if (mismatch_count == 0 && expected_visits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (expected_visits.size() != 0)
        $display("ERROR: %0d predicted visits never came out", expected_visits.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
